// ===== rtl/core/mme_pkg.sv =====
package mme_pkg;

   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 16;

   // fixed field widths
   localparam int ACC_W      = 35;
   localparam int CSR_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int FUNC_W     = 2;
   localparam int POS_W      = 3;
   localparam int IDX_EXT_W  = 4;   // holds any index up to 15
   localparam int DIM_EXT_W  = 5;   // holds any dimension up to 16

   localparam logic [CSR_W-1:0] DIM_RESET = CSR_W'(8);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_A = 2'd0,
      FUNC_WRITE_B = 2'd1,
      FUNC_RUN     = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_A_ROWS    = 2'd0,
      REG_INNER_LEN = 2'd1,
      REG_B_COLS    = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   // one output element travelling down the cell chain
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [IDX_EXT_W-1:0] row;
      logic [IDX_EXT_W-1:0] col;
   } token_type;

   // store write control for one cell
   typedef struct packed {
      logic                 a_en;
      logic                 b_en;
      logic [IDX_EXT_W-1:0] a_addr;
      logic [IDX_EXT_W-1:0] b_addr;
   } cell_wr_type;

   // dimension register saturated to the array size
   function automatic logic [DIM_EXT_W-1:0] eff_dim(input logic [CSR_W-1:0] r, input int max_dim);
      logic [DIM_EXT_W-1:0] v;
      logic [DIM_EXT_W-1:0] lim;
      v   = DIM_EXT_W'(r);
      lim = DIM_EXT_W'(max_dim);
      return (v > lim) ? lim : v;
   endfunction

endpackage

// ===== rtl/core/matrix_multiply_engine.sv =====
// Write transactions (A or B element) are taken one per cycle unless stalled.
// A run issues one result element per cycle into a chain of MAX_DIM MAC cells
// while the output is not stalled; each element passes every cell register and
// the output register; a run delivers m_dim * n_dim elements.
// The next transaction is taken once the last element has left the cell chain.
// Synchronous active-high reset clears control and sets all dimensions to 8.
module matrix_multiply_engine #(
   parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mme_pkg::FUNC_W-1:0]          req_func,
   input  logic [mme_pkg::POS_W-1:0]           req_row_index,
   input  logic [mme_pkg::POS_W-1:0]           req_col_index,
   input  logic signed [DATA_WIDTH-1:0]        req_elem_value,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mme_pkg::POS_W-1:0]           rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]           rsp_out_col,
   output logic signed [mme_pkg::ACC_W-1:0]    rsp_out_value,
   output logic                                rsp_last_flag,

   input  logic                                csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mme_pkg::CSR_W-1:0]           csr_data
);

   localparam int IDXW = $clog2(MAX_DIM);
   localparam int DW   = mme_pkg::DIM_EXT_W;
   localparam int XW   = mme_pkg::IDX_EXT_W;
   localparam int AW   = mme_pkg::ACC_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   // configuration
   logic [mme_pkg::CSR_W-1:0] a_rows_ff, inner_len_ff, b_cols_ff;
   logic [DW-1:0]             m_dim, k_dim, n_dim;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= mme_pkg::DIM_RESET;
         inner_len_ff <= mme_pkg::DIM_RESET;
         b_cols_ff    <= mme_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (mme_pkg::reg_index_type'(csr_index))
            mme_pkg::REG_A_ROWS:    a_rows_ff    <= csr_data;
            mme_pkg::REG_INNER_LEN: inner_len_ff <= csr_data;
            mme_pkg::REG_B_COLS:    b_cols_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign m_dim = mme_pkg::eff_dim(a_rows_ff, MAX_DIM);
   assign k_dim = mme_pkg::eff_dim(inner_len_ff, MAX_DIM);
   assign n_dim = mme_pkg::eff_dim(b_cols_ff, MAX_DIM);

   // chain wiring
   mme_pkg::token_type tok_w [MAX_DIM+1];
   logic [AW-1:0]      sum_w [MAX_DIM+1];
   logic [MAX_DIM-1:0] chain_valid;
   logic               chain_busy;
   logic               adv;

   // sequencer
   seq_state_type state_ff, state_in;
   logic [IDXW-1:0] i_ff, i_in, j_ff, j_in;
   logic            req_acc;
   logic            run_start;
   logic            last_i, last_j;
   logic [DW-1:0]   row_d, col_d;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff == ST_RUN) || chain_busy;
   assign row_d     = DW'(req_row_index);
   assign col_d     = DW'(req_col_index);
   assign run_start = req_acc && (mme_pkg::func_type'(req_func) == mme_pkg::FUNC_RUN) &&
                      (m_dim != '0) && (n_dim != '0);
   assign last_i    = (DW'(i_ff) + DW'(1)) == m_dim;
   assign last_j    = (DW'(j_ff) + DW'(1)) == n_dim;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + IDXW'(1);
                  if (last_i) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  j_in = j_ff + IDXW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      tok_w[0].valid = (state_ff == ST_RUN);
      tok_w[0].last  = last_i && last_j;
      tok_w[0].row   = XW'(i_ff);
      tok_w[0].col   = XW'(j_ff);
   end
   assign sum_w[0] = '0;

   // store writes: column f of A and row f of B live in cell f
   logic wr_a_ok, wr_b_ok;
   assign wr_a_ok = req_acc && (mme_pkg::func_type'(req_func) == mme_pkg::FUNC_WRITE_A) &&
                    (row_d < m_dim) && (col_d < k_dim);
   assign wr_b_ok = req_acc && (mme_pkg::func_type'(req_func) == mme_pkg::FUNC_WRITE_B) &&
                    (row_d < k_dim) && (col_d < n_dim);

   genvar f;
   generate
      for (f = 0; f < MAX_DIM; f++) begin : g_cell
         mme_pkg::cell_wr_type wr;
         logic                 active;

         assign wr.a_en   = wr_a_ok && (col_d == DW'(f));
         assign wr.b_en   = wr_b_ok && (row_d == DW'(f));
         assign wr.a_addr = XW'(req_row_index);
         assign wr.b_addr = XW'(req_col_index);
         assign active    = DW'(f) < k_dim;

         mme_cell #(
            .MAX_DIM    (MAX_DIM),
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .adv     (adv),
            .active  (active),
            .wr      (wr),
            .wr_data (req_elem_value),
            .tok_in  (tok_w[f]),
            .sum_in  (sum_w[f]),
            .tok_out (tok_w[f+1]),
            .sum_out (sum_w[f+1])
         );

         assign chain_valid[f] = tok_w[f+1].valid;
      end
   endgenerate

   assign chain_busy = |chain_valid;

   // output register; the whole chain holds while it is stalled
   logic                 rsp_valid_ff;
   logic [mme_pkg::POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [AW-1:0]        rsp_value_ff;
   logic                 rsp_last_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tok_w[MAX_DIM].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tok_w[MAX_DIM].valid) begin
         rsp_row_ff   <= tok_w[MAX_DIM].row[mme_pkg::POS_W-1:0];
         rsp_col_ff   <= tok_w[MAX_DIM].col[mme_pkg::POS_W-1:0];
         rsp_value_ff <= sum_w[MAX_DIM];
         rsp_last_ff  <= tok_w[MAX_DIM].last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last_flag = rsp_last_ff;

   // checks
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_run_enters: assert property (@(posedge clock) disable iff (reset)
      run_start |=> (state_ff == ST_RUN))
      else $error("accepted run did not start issuing");

   a_write_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (wr_a_ok || wr_b_ok) |-> (!chain_busy && state_ff == ST_IDLE))
      else $error("store written while a run is in flight");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_row_ff == mme_pkg::POS_W'(m_dim - DW'(1))) &&
         (rsp_col_ff == mme_pkg::POS_W'(n_dim - DW'(1))))
      else $error("last element not at the final row and column");

endmodule

// ===== rtl/core/mme_cell.sv =====
module mme_cell #(
   parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              active,
   input  mme_pkg::cell_wr_type              wr,
   input  logic signed [DATA_WIDTH-1:0]      wr_data,
   input  mme_pkg::token_type                tok_in,
   input  logic [mme_pkg::ACC_W-1:0]         sum_in,
   output mme_pkg::token_type                tok_out,
   output logic [mme_pkg::ACC_W-1:0]         sum_out
);

   localparam int IDXW = $clog2(MAX_DIM);
   localparam int PW   = 2 * DATA_WIDTH;
   localparam int AW   = mme_pkg::ACC_W;

   // a_ff holds one column of A, b_ff one row of B
   logic signed [DATA_WIDTH-1:0] a_ff [MAX_DIM];
   logic signed [DATA_WIDTH-1:0] b_ff [MAX_DIM];

   mme_pkg::token_type tok_ff;
   logic [AW-1:0]      sum_ff;
   logic [AW-1:0]      sum_in_nxt;

   logic signed [DATA_WIDTH-1:0] a_rd;
   logic signed [DATA_WIDTH-1:0] b_rd;
   logic signed [PW-1:0]         prod;
   logic [PW+AW-1:0]             prod_ext;

   assign a_rd     = a_ff[tok_in.row[IDXW-1:0]];
   assign b_rd     = b_ff[tok_in.col[IDXW-1:0]];
   assign prod     = a_rd * b_rd;
   assign prod_ext = {{AW{prod[PW-1]}}, prod};

   // modulo 2^35 accumulate
   assign sum_in_nxt = active ? (sum_in + prod_ext[AW-1:0]) : sum_in;

   always_ff @(posedge clock) begin
      if (wr.a_en) begin
         a_ff[wr.a_addr[IDXW-1:0]] <= wr_data;
      end
      if (wr.b_en) begin
         b_ff[wr.b_addr[IDXW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in_nxt;
      end
   end

   assign tok_out = tok_ff;
   assign sum_out = sum_ff;

endmodule

// ===== bench/matrix_multiply_engine_tb.sv =====
module matrix_multiply_engine_tb;

   localparam int MAX_DIM       = mme_pkg::MAX_DIM_DEF;
   localparam int DW            = mme_pkg::DATA_WIDTH_DEF;
   localparam int POS_W         = mme_pkg::POS_W;
   localparam int ACC_W         = mme_pkg::ACC_W;
   localparam int CSR_W         = mme_pkg::CSR_W;
   localparam int FUNC_W        = mme_pkg::FUNC_W;
   localparam int CSR_IDX_W     = mme_pkg::CSR_IDX_W;
   localparam int SETTLE_CYCLES = 2 * MAX_DIM + 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

   typedef struct packed {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } elem_type;

   typedef enum {ROW_SHAPE, ROW_ITEM} row_kind_type;
   typedef enum {CHK_MODEL, CHK_SINGLE, CHK_EMPTY} check_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_W-1:0]        m, k, n;
      mme_pkg::func_type       fn;
      logic [POS_W-1:0]        r, c;
      logic signed [DW-1:0]    v;
      bit                      fill_min;
      check_type               chk;
      logic signed [ACC_W-1:0] exp_value;
   } script_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [FUNC_W-1:0]       req_func;
   logic [POS_W-1:0]        req_row_index;
   logic [POS_W-1:0]        req_col_index;
   logic signed [DW-1:0]    req_elem_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [POS_W-1:0]        rsp_out_row;
   logic [POS_W-1:0]        rsp_out_col;
   logic signed [ACC_W-1:0] rsp_out_value;
   logic                    rsp_last_flag;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_data;

   // mirror of the engine
   logic signed [DW-1:0] mat_a [MAX_DIM*MAX_DIM];
   logic signed [DW-1:0] mat_b [MAX_DIM*MAX_DIM];
   bit                   a_loaded [MAX_DIM*MAX_DIM];
   bit                   b_loaded [MAX_DIM*MAX_DIM];
   logic [CSR_W-1:0]     shape_rows, shape_inner, shape_cols;

   elem_type        pending_elems[$];
   script_row_type  script[$];
   int              mismatches = 0;
   int              send_idle_pct = 15;
   int              recv_idle_pct = 59;
   int unsigned     cycle_count = 0;

   matrix_multiply_engine uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last_flag  (rsp_last_flag),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b1;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      elem_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_elems.size() == 0) begin
            $error("unexpected result transaction: row %0d col %0d value %0d",
                   rsp_out_row, rsp_out_col, rsp_out_value);
            mismatches++;
         end else begin
            want = pending_elems.pop_front();
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               mismatches++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               mismatches++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
               mismatches++;
            end
            if (rsp_last_flag !== want.last) begin
               $error("last_flag: expected %0d, got %0d", want.last, rsp_last_flag);
               mismatches++;
            end
         end
      end
   end

   function automatic int dim_of(logic [CSR_W-1:0] r);
      return (r > MAX_DIM) ? MAX_DIM : int'(r);
   endfunction

   function automatic logic signed [DW-1:0] rand_elem();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return VAL_MIN;
      if (sel < 20) return VAL_MAX;
      return DW'($urandom);
   endfunction

   // every element of A*B in row-major order, exact sum wrapped to ACC_W bits
   function automatic void predict_product(int m, int k, int n);
      elem_type                e;
      logic signed [ACC_W-1:0] acc;
      longint                  prod;
      for (int i = 0; i < m; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int f = 0; f < k; f++) begin
               prod = mat_a[i*MAX_DIM + f] * mat_b[f*MAX_DIM + j];
               acc  = acc + ACC_W'(prod);
            end
            e.row   = POS_W'(i);
            e.col   = POS_W'(j);
            e.value = acc;
            e.last  = (i == m - 1) && (j == n - 1);
            pending_elems.push_back(e);
         end
      end
   endfunction

   function automatic void apply_item(mme_pkg::func_type fn, logic [POS_W-1:0] r,
                                      logic [POS_W-1:0] c, logic signed [DW-1:0] v,
                                      bit model);
      int m, k, n, idx;
      m   = dim_of(shape_rows);
      k   = dim_of(shape_inner);
      n   = dim_of(shape_cols);
      idx = int'(r) * MAX_DIM + int'(c);
      case (fn)
         mme_pkg::FUNC_WRITE_A: begin
            if (r < m && c < k) begin
               mat_a[idx]    = v;
               a_loaded[idx] = 1'b1;
            end
         end
         mme_pkg::FUNC_WRITE_B: begin
            if (r < k && c < n) begin
               mat_b[idx]    = v;
               b_loaded[idx] = 1'b1;
            end
         end
         mme_pkg::FUNC_RUN: begin
            if (model) predict_product(m, k, n);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input mme_pkg::func_type fn, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic signed [DW-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_row_index  <= r;
      req_col_index  <= c;
      req_elem_value <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic issue(input mme_pkg::func_type fn, input logic [POS_W-1:0] r,
                        input logic [POS_W-1:0] c, input logic signed [DW-1:0] v);
      send_item(fn, r, c, v);
      apply_item(fn, r, c, v, 1'b1);
   endtask

   // a run may only read entries written since reset
   task automatic load_missing(input bit all_min);
      int m, k, n;
      m = dim_of(shape_rows);
      k = dim_of(shape_inner);
      n = dim_of(shape_cols);
      for (int i = 0; i < m; i++)
         for (int f = 0; f < k; f++)
            if (!a_loaded[i*MAX_DIM + f])
               issue(mme_pkg::FUNC_WRITE_A, POS_W'(i), POS_W'(f),
                     all_min ? VAL_MIN : rand_elem());
      for (int f = 0; f < k; f++)
         for (int j = 0; j < n; j++)
            if (!b_loaded[f*MAX_DIM + j])
               issue(mme_pkg::FUNC_WRITE_B, POS_W'(f), POS_W'(j),
                     all_min ? VAL_MIN : rand_elem());
   endtask

   task automatic run_product();
      load_missing(1'b0);
      issue(mme_pkg::FUNC_RUN, POS_W'($urandom), POS_W'($urandom), DW'($urandom));
   endtask

   // shape changes only once the engine has drained
   task automatic set_shape(input logic [CSR_W-1:0] m, input logic [CSR_W-1:0] k,
                            input logic [CSR_W-1:0] n);
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= mme_pkg::REG_A_ROWS;
      csr_data  <= m;
      @(posedge clock);
      csr_index <= mme_pkg::REG_INNER_LEN;
      csr_data  <= k;
      @(posedge clock);
      csr_index <= mme_pkg::REG_NONE;
      csr_data  <= CSR_W'($urandom);
      @(posedge clock);
      csr_index <= mme_pkg::REG_B_COLS;
      csr_data  <= n;
      @(posedge clock);
      csr_we      <= 1'b0;
      shape_rows  = m;
      shape_inner = k;
      shape_cols  = n;
   endtask

   function automatic logic [CSR_W-1:0] rand_dim();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 6) return '0;
      if (sel < 12) return CSR_W'(MAX_DIM);
      if (sel < 16) return CSR_W'($urandom_range(MAX_DIM + 1, 15));
      return CSR_W'($urandom_range(1, 4));
   endfunction

   task automatic random_block(input int count);
      int                sel, rmax, cmax;
      mme_pkg::func_type fn;
      logic [POS_W-1:0]  r, c;
      for (int t = 0; t < count; t++) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            run_product();
         end else if (sel < 16) begin
            issue(mme_pkg::FUNC_NONE, POS_W'($urandom), POS_W'($urandom), DW'($urandom));
         end else begin
            fn   = (sel < 58) ? mme_pkg::FUNC_WRITE_A : mme_pkg::FUNC_WRITE_B;
            rmax = (fn == mme_pkg::FUNC_WRITE_A) ? dim_of(shape_rows) : dim_of(shape_inner);
            cmax = (fn == mme_pkg::FUNC_WRITE_A) ? dim_of(shape_inner) : dim_of(shape_cols);
            // mostly in shape, the rest anywhere in the index range
            if (rmax > 0 && cmax > 0 && $urandom_range(0, 3) != 0) begin
               r = POS_W'($urandom_range(0, rmax - 1));
               c = POS_W'($urandom_range(0, cmax - 1));
            end else begin
               r = POS_W'($urandom);
               c = POS_W'($urandom);
            end
            issue(fn, r, c, rand_elem());
         end
      end
      run_product();
   endtask

   function automatic script_row_type shape_row(logic [CSR_W-1:0] m, logic [CSR_W-1:0] k,
                                                logic [CSR_W-1:0] n);
      script_row_type s;
      s.kind = ROW_SHAPE;
      s.m    = m;
      s.k    = k;
      s.n    = n;
      return s;
   endfunction

   function automatic script_row_type item_row(mme_pkg::func_type fn, logic [POS_W-1:0] r,
                                               logic [POS_W-1:0] c, logic signed [DW-1:0] v,
                                               check_type chk,
                                               logic signed [ACC_W-1:0] exp_value,
                                               bit fill_min);
      script_row_type s;
      s.kind      = ROW_ITEM;
      s.fn        = fn;
      s.r         = r;
      s.c         = c;
      s.v         = v;
      s.chk       = chk;
      s.exp_value = exp_value;
      s.fill_min  = fill_min;
      return s;
   endfunction

   initial begin
      script_row_type row;
      elem_type       single;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= mme_pkg::FUNC_NONE;
      req_row_index  <= '0;
      req_col_index  <= '0;
      req_elem_value <= '0;
      csr_we         <= 1'b0;
      csr_index      <= mme_pkg::REG_NONE;
      csr_data       <= '0;
      repeat (6) @(posedge clock);
      reset       <= 1'b0;
      shape_rows  = mme_pkg::DIM_RESET;
      shape_inner = mme_pkg::DIM_RESET;
      shape_cols  = mme_pkg::DIM_RESET;

      // 1x1x1 extremes, ignored writes and the unused function code
      script.push_back(shape_row(1, 1, 1));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_A, 0, 0, VAL_MIN, CHK_MODEL, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_B, 0, 0, VAL_MIN, CHK_MODEL, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_SINGLE, 35'sd1073741824, 0));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_A, 0, 0, VAL_MAX, CHK_MODEL, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 7, 7, -1, CHK_SINGLE,
                                -35'sd1073709056, 0));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_A, 1, 0, 7, CHK_EMPTY, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_A, 0, 7, 7, CHK_EMPTY, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_B, 7, 7, 7, CHK_EMPTY, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_NONE, 7, 7, -1, CHK_EMPTY, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_SINGLE,
                                -35'sd1073709056, 0));
      // degenerate shapes
      script.push_back(shape_row(0, 1, 1));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_EMPTY, 0, 0));
      script.push_back(shape_row(1, 0, 1));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_SINGLE, 0, 0));
      script.push_back(shape_row(1, 1, 0));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_EMPTY, 0, 0));
      // largest sum: eight products of the most negative element
      script.push_back(shape_row(1, 8, 1));
      script.push_back(item_row(mme_pkg::FUNC_WRITE_A, 0, 0, VAL_MIN, CHK_MODEL, 0, 0));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_SINGLE, 35'sd8589934592, 1));
      // registers above the array size saturate to it: a full 8x8x8 run, then 8x3x8
      script.push_back(shape_row(15, 15, 15));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 3, 5, 0, CHK_MODEL, 0, 0));
      script.push_back(shape_row(9, 3, 12));
      script.push_back(item_row(mme_pkg::FUNC_RUN, 0, 0, 0, CHK_MODEL, 0, 0));

      foreach (script[s]) begin
         row = script[s];
         if (row.kind == ROW_SHAPE) begin
            set_shape(row.m, row.k, row.n);
         end else begin
            if (row.fn == mme_pkg::FUNC_RUN) load_missing(row.fill_min);
            send_item(row.fn, row.r, row.c, row.v);
            apply_item(row.fn, row.r, row.c, row.v, row.chk == CHK_MODEL);
            if (row.chk == CHK_SINGLE) begin
               single = '{row: '0, col: '0, value: row.exp_value, last: 1'b1};
               pending_elems.push_back(single);
            end
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 15 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            set_shape(rand_dim(), rand_dim(), rand_dim());
            random_block(6);
         end
      end

      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
